FILE: rtl/world_to_screen_projection_top_macros.svh
// Assertion macros for the world-to-screen projection block.
`ifndef WORLD_TO_SCREEN_PROJECTION_TOP_MACROS_SVH
`define WORLD_TO_SCREEN_PROJECTION_TOP_MACROS_SVH
`ifndef ASSERT_OFF
`define WTS_ASSERT_IMPL(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);
`define WTS_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);
`else
`define WTS_ASSERT_IMPL(label, clk, rst_n, ante, cons, msg)
`define WTS_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg)
`endif
`endif

FILE: rtl/wts_pkg.sv
`timescale 1ns / 1ps
package wts_pkg;
    localparam int FRAC_BITS_DEF = 16;
    localparam int Q_W = 32;
    localparam int SIZE_W = 16;
    localparam int NDC_LIM_BIT = 47;
    localparam int NDC_W = NDC_LIM_BIT + 1;
    localparam logic [SIZE_W-1:0] WIDTH_RESET = 16'd1920;
    localparam logic [SIZE_W-1:0] HEIGHT_RESET = 16'd1080;
    // register indexes
    localparam logic CFG_WIDTH = 1'b0;
    localparam logic CFG_HEIGHT = 1'b1;
    // item actions
    localparam logic ACT_TRANSFORM = 1'b0;
    localparam logic ACT_LOAD = 1'b1;
    localparam logic [Q_W-1:0] Q_MAX = 32'h7fff_ffff;
    localparam logic [Q_W-1:0] Q_MIN = 32'h8000_0000;

    function automatic logic [Q_W-1:0] mag32(input logic [Q_W-1:0] v);
        mag32 = v[Q_W-1] ? (~v + 32'd1) : v;
    endfunction
endpackage

FILE: rtl/world_to_screen_projection_top.sv
`timescale 1ns / 1ps
// Channel   | Handshake            | Payload
// ----------+----------------------+-------------------------------------------
// input     | in_valid / in_stall  | action, element_index, element_value,
//           |                      | point_x, point_y, point_z
// output    | out_valid/ out_stall | screen_x, screen_y, clip_w, bad_result
// config    | cfg_valid/ cfg_ready | cfg_index (0 width, 1 height), cfg_data
//
// One item enters per cycle unless the output stalls; data is Q16.16 by default.
// Stages: six of matrix work, one per quotient bit of the restoring divider,
// then clamp, split scale multiply and saturation into the output register.
// Reset clears all valid bits, both matrices and loads the default screen size.
// A stalled output register freezes the whole pipeline; in_stall follows it.
// A load item writes the view matrix when accepted and the projection matrix
// when it reaches the projection stage, so every transform sees the loads
// ahead of it and none behind it.
`include "world_to_screen_projection_top_macros.svh"
module world_to_screen_projection_top #(
    parameter int FRAC_BITS = wts_pkg::FRAC_BITS_DEF
) (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        in_valid,
    output logic        in_stall,
    input  logic        action,
    input  logic [4:0]  element_index,
    input  logic signed [31:0] element_value,
    input  logic signed [31:0] point_x,
    input  logic signed [31:0] point_y,
    input  logic signed [31:0] point_z,
    output logic        out_valid,
    input  logic        out_stall,
    output logic signed [31:0] screen_x,
    output logic signed [31:0] screen_y,
    output logic signed [31:0] clip_w,
    output logic        bad_result,
    input  logic        cfg_valid,
    output logic        cfg_ready,
    input  logic        cfg_index,
    input  logic [15:0] cfg_data
);
    localparam int PW = 64 - FRAC_BITS;        // product after dropping fraction
    localparam int SW = PW + 2;                // sum of four products
    localparam int DW = 32 + FRAC_BITS;        // dividend / quotient magnitude
    localparam int MW = (DW > wts_pkg::NDC_W) ? DW : wts_pkg::NDC_W;
    localparam int NW = wts_pkg::NDC_W;
    localparam int HW = NW / 2;
    localparam logic signed [31:0] ONE_Q = 32'(1) << FRAC_BITS;

    typedef struct packed {
        logic [32:0]   rem;
        logic [DW-1:0] dvd;
        logic [DW-1:0] quo;
    } div_t;

    typedef struct packed {
        logic        x_neg;
        logic        x_zero;
        logic        y_neg;
        logic        y_zero;
        logic        wzero;
        logic        bad;
        logic [31:0] w;
    } side_t;

    function automatic logic [32:0] sat32(input logic signed [SW-1:0] v);
        logic signed [SW-1:0] hi;
        logic signed [SW-1:0] lo;
        hi = {{(SW-32){1'b0}}, wts_pkg::Q_MAX};
        lo = {{(SW-32){1'b1}}, wts_pkg::Q_MIN};
        if (v > hi)
            sat32 = {1'b1, wts_pkg::Q_MAX};
        else if (v < lo)
            sat32 = {1'b1, wts_pkg::Q_MIN};
        else
            sat32 = {1'b0, v[31:0]};
    endfunction

    function automatic div_t div_step(input div_t s, input logic [31:0] d);
        logic [32:0] trial;
        logic        ge;
        trial = {s.rem[31:0], s.dvd[DW-1]};
        ge = (trial >= {1'b0, d});
        div_step.rem = ge ? (trial - {1'b0, d}) : trial;
        div_step.dvd = s.dvd << 1;
        div_step.quo = {s.quo[DW-2:0], ge};
    endfunction

    // magnitude of (ndc * size) / 2 with sign and saturation: {bad, value}
    function automatic logic [32:0] finish(input logic [HW+15:0] lo,
                                           input logic [HW+15:0] hi,
                                           input logic neg);
        logic [63:0] tot;
        logic [62:0] half;
        tot = {hi, {HW{1'b0}}} + 64'(lo);
        half = tot[63:1];
        if (!neg) begin
            if (half > 63'(wts_pkg::Q_MAX))
                finish = {1'b1, wts_pkg::Q_MAX};
            else
                finish = {1'b0, half[31:0]};
        end
        else begin
            if (half > 63'(wts_pkg::Q_MIN))
                finish = {1'b1, wts_pkg::Q_MIN};
            else
                finish = {1'b0, ~half[31:0] + 32'd1};
        end
    endfunction

    logic advance;
    logic in_acc;

    assign advance = !(out_valid && out_stall);
    assign in_stall = !advance;
    assign in_acc = in_valid && advance;
    assign cfg_ready = 1'b1;

    // configuration
    logic [15:0] width_reg;
    logic [15:0] height_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            width_reg <= wts_pkg::WIDTH_RESET;
            height_reg <= wts_pkg::HEIGHT_RESET;
        end
        else if (cfg_valid && cfg_ready)
        begin
            case (cfg_index)
                wts_pkg::CFG_WIDTH:  width_reg <= cfg_data;
                wts_pkg::CFG_HEIGHT: height_reg <= cfg_data;
                default: ;
            endcase
        end
    end

    // matrices
    logic signed [31:0] view_reg [16];
    logic signed [31:0] proj_reg [16];

    // stage A: accepted item
    logic               a_valid_reg;
    logic               a_load_reg;
    logic [4:0]         a_idx_reg;
    logic signed [31:0] a_val_reg;
    logic signed [31:0] a_p_reg [3];
    // stage B: view products
    logic               b_valid_reg;
    logic               b_load_reg;
    logic [4:0]         b_idx_reg;
    logic signed [31:0] b_val_reg;
    logic signed [PW-1:0] b_prod_reg [16];
    logic signed [PW-1:0] b_prod_next [16];
    // stage C: view result
    logic               c_valid_reg;
    logic               c_load_reg;
    logic [4:0]         c_idx_reg;
    logic signed [31:0] c_val_reg;
    logic signed [31:0] c_v_reg [4];
    logic signed [31:0] c_v_next [4];
    logic               c_bad_reg;
    logic               c_bad_next;
    // stage D: projection products
    logic               d_valid_reg;
    logic               d_bad_reg;
    logic signed [PW-1:0] d_prod_reg [16];
    logic signed [PW-1:0] d_prod_next [16];
    // stage E: clip result
    logic               e_valid_reg;
    logic               e_bad_reg;
    logic               e_bad_next;
    logic signed [31:0] e_c_reg [4];
    logic signed [31:0] e_c_next [4];
    // divider chain, index 0 loaded from stage E
    logic        dv_valid_reg [DW+1];
    div_t        dvx_reg [DW+1];
    div_t        dvy_reg [DW+1];
    logic [31:0] dvd_reg [DW+1];
    side_t       dvs_reg [DW+1];
    // stage G: clamped magnitudes
    logic          g_valid_reg;
    logic [NW-1:0] g_x_reg;
    logic [NW-1:0] g_y_reg;
    side_t         g_side_reg;
    logic [MW-1:0] lim;
    logic [MW-1:0] qx_ext;
    logic [MW-1:0] qy_ext;
    // stage H: partial products of the scale
    logic           h_valid_reg;
    logic [HW+15:0] h_xlo_reg;
    logic [HW+15:0] h_xhi_reg;
    logic [HW+15:0] h_ylo_reg;
    logic [HW+15:0] h_yhi_reg;
    side_t          h_side_reg;
    // output register
    logic               out_valid_reg;
    logic signed [31:0] sx_reg;
    logic signed [31:0] sy_reg;
    logic signed [31:0] w_reg;
    logic               bad_reg;
    logic [32:0]        fx;
    logic [32:0]        fy;
    logic signed [31:0] sx_next;
    logic signed [31:0] sy_next;
    logic               bad_next;

    // view write at acceptance, projection write when the load reaches stage C
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i < 16; i++)
            begin
                view_reg[i] <= '0;
                proj_reg[i] <= '0;
            end
        end
        else
        begin
            if (in_acc && action == wts_pkg::ACT_LOAD && !element_index[4])
                view_reg[element_index[3:0]] <= element_value;
            if (advance && c_valid_reg && c_load_reg && c_idx_reg[4])
                proj_reg[c_idx_reg[3:0]] <= c_val_reg;
        end
    end

    // products of the view stage: the fourth point term is exactly one
    always_comb
    begin
        logic signed [63:0] prod;
        logic signed [31:0] pv;
        for (int k = 0; k < 16; k++)
        begin
            pv = ((k % 4) == 3) ? ONE_Q : a_p_reg[k % 4];
            prod = 64'(view_reg[k]) * 64'(pv);
            b_prod_next[k] = prod[63:FRAC_BITS];
        end
    end

    always_comb
    begin
        logic signed [SW-1:0] acc;
        logic [32:0] s;
        c_bad_next = 1'b0;
        for (int i = 0; i < 4; i++)
        begin
            acc = SW'(b_prod_reg[4*i]) + SW'(b_prod_reg[4*i+1])
                + SW'(b_prod_reg[4*i+2]) + SW'(b_prod_reg[4*i+3]);
            s = sat32(acc);
            c_v_next[i] = s[31:0];
            c_bad_next = c_bad_next | s[32];
        end
    end

    always_comb
    begin
        logic signed [63:0] prod;
        for (int k = 0; k < 16; k++)
        begin
            prod = 64'(proj_reg[k]) * 64'(c_v_reg[k % 4]);
            d_prod_next[k] = prod[63:FRAC_BITS];
        end
    end

    always_comb
    begin
        logic signed [SW-1:0] acc;
        logic [32:0] s;
        e_bad_next = d_bad_reg;
        for (int i = 0; i < 4; i++)
        begin
            acc = SW'(d_prod_reg[4*i]) + SW'(d_prod_reg[4*i+1])
                + SW'(d_prod_reg[4*i+2]) + SW'(d_prod_reg[4*i+3]);
            s = sat32(acc);
            e_c_next[i] = s[31:0];
            e_bad_next = e_bad_next | s[32];
        end
    end

    // valid bits
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            a_valid_reg <= 1'b0;
            b_valid_reg <= 1'b0;
            c_valid_reg <= 1'b0;
            d_valid_reg <= 1'b0;
            e_valid_reg <= 1'b0;
            dv_valid_reg[0] <= 1'b0;
            g_valid_reg <= 1'b0;
            h_valid_reg <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else if (advance)
        begin
            a_valid_reg <= in_acc;
            b_valid_reg <= a_valid_reg;
            c_valid_reg <= b_valid_reg;
            // drop loads here: they give no result
            d_valid_reg <= c_valid_reg && !c_load_reg;
            e_valid_reg <= d_valid_reg;
            dv_valid_reg[0] <= e_valid_reg;
            g_valid_reg <= dv_valid_reg[DW];
            h_valid_reg <= g_valid_reg;
            out_valid_reg <= h_valid_reg;
        end
    end

    // matrix stages payload
    always_ff @(posedge clk)
    begin
        if (advance)
        begin
            a_load_reg <= (action == wts_pkg::ACT_LOAD);
            a_idx_reg <= element_index;
            a_val_reg <= element_value;
            a_p_reg[0] <= point_x;
            a_p_reg[1] <= point_y;
            a_p_reg[2] <= point_z;
            b_load_reg <= a_load_reg;
            b_idx_reg <= a_idx_reg;
            b_val_reg <= a_val_reg;
            b_prod_reg <= b_prod_next;
            c_load_reg <= b_load_reg;
            c_idx_reg <= b_idx_reg;
            c_val_reg <= b_val_reg;
            c_v_reg <= c_v_next;
            c_bad_reg <= c_bad_next;
            d_prod_reg <= d_prod_next;
            d_bad_reg <= c_bad_reg;
            e_c_reg <= e_c_next;
            e_bad_reg <= e_bad_next;
        end
    end

    // divider entry: magnitudes of clip x, y shifted up, and of w
    always_ff @(posedge clk)
    begin
        if (advance)
        begin
            dvx_reg[0].rem <= '0;
            dvx_reg[0].quo <= '0;
            dvx_reg[0].dvd <= {wts_pkg::mag32(e_c_reg[0]), {FRAC_BITS{1'b0}}};
            dvy_reg[0].rem <= '0;
            dvy_reg[0].quo <= '0;
            dvy_reg[0].dvd <= {wts_pkg::mag32(e_c_reg[1]), {FRAC_BITS{1'b0}}};
            dvd_reg[0] <= wts_pkg::mag32(e_c_reg[3]);
            dvs_reg[0].x_neg <= e_c_reg[0][31];
            dvs_reg[0].x_zero <= (e_c_reg[0] == '0);
            dvs_reg[0].y_neg <= e_c_reg[1][31];
            dvs_reg[0].y_zero <= (e_c_reg[1] == '0);
            dvs_reg[0].wzero <= (e_c_reg[3] == '0);
            dvs_reg[0].bad <= e_bad_reg;
            dvs_reg[0].w <= e_c_reg[3];
        end
    end

    // one quotient bit per stage
    for (genvar k = 0; k < DW; k++)
    begin : g_div
        always_ff @(posedge clk or negedge rst_n)
        begin
            if (!rst_n)
                dv_valid_reg[k+1] <= 1'b0;
            else if (advance)
                dv_valid_reg[k+1] <= dv_valid_reg[k];
        end

        always_ff @(posedge clk)
        begin
            if (advance)
            begin
                dvx_reg[k+1] <= div_step(dvx_reg[k], dvd_reg[k]);
                dvy_reg[k+1] <= div_step(dvy_reg[k], dvd_reg[k]);
                dvd_reg[k+1] <= dvd_reg[k];
                dvs_reg[k+1] <= dvs_reg[k];
            end
        end
    end

    // clamp the normalized magnitude
    assign lim = MW'(1) << wts_pkg::NDC_LIM_BIT;
    assign qx_ext = MW'(dvx_reg[DW].quo);
    assign qy_ext = MW'(dvy_reg[DW].quo);

    always_ff @(posedge clk)
    begin
        if (advance)
        begin
            g_x_reg <= (qx_ext > lim) ? lim[NW-1:0] : qx_ext[NW-1:0];
            g_y_reg <= (qy_ext > lim) ? lim[NW-1:0] : qy_ext[NW-1:0];
            g_side_reg <= dvs_reg[DW];
            // split the scale multiply into two halves
            h_xlo_reg <= (HW+16)'(g_x_reg[HW-1:0]) * (HW+16)'(width_reg);
            h_xhi_reg <= (HW+16)'(g_x_reg[NW-1:HW]) * (HW+16)'(width_reg);
            h_ylo_reg <= (HW+16)'(g_y_reg[HW-1:0]) * (HW+16)'(height_reg);
            h_yhi_reg <= (HW+16)'(g_y_reg[NW-1:HW]) * (HW+16)'(height_reg);
            h_side_reg <= g_side_reg;
        end
    end

    // finish, saturate, and override for a zero w; the quotient sign is
    // the sign of the clip value combined with the sign of w
    always_comb
    begin
        fx = finish(h_xlo_reg, h_xhi_reg, h_side_reg.x_neg ^ h_side_reg.w[31]);
        fy = finish(h_ylo_reg, h_yhi_reg, h_side_reg.y_neg ^ h_side_reg.w[31]);
        if (h_side_reg.wzero)
        begin
            sx_next = h_side_reg.x_zero ? '0
                    : (h_side_reg.x_neg ? wts_pkg::Q_MIN : wts_pkg::Q_MAX);
            sy_next = h_side_reg.y_zero ? '0
                    : (h_side_reg.y_neg ? wts_pkg::Q_MIN : wts_pkg::Q_MAX);
            bad_next = 1'b1;
        end
        else
        begin
            sx_next = fx[31:0];
            sy_next = fy[31:0];
            bad_next = h_side_reg.bad | fx[32] | fy[32];
        end
    end

    always_ff @(posedge clk)
    begin
        if (advance)
        begin
            sx_reg <= sx_next;
            sy_reg <= sy_next;
            w_reg <= h_side_reg.w;
            bad_reg <= bad_next;
        end
    end

    assign out_valid = out_valid_reg;
    assign screen_x = sx_reg;
    assign screen_y = sy_reg;
    assign clip_w = w_reg;
    assign bad_result = bad_reg;

    // a clean result always has a nonzero w
    `WTS_ASSERT_IMPL(a_clean_w, clk, rst_n, out_valid && !bad_result,
                     clip_w != '0, "clean result with zero w")
    // a load leaving the projection stage leaves a bubble behind it
    `WTS_ASSERT_NEXT(a_load_drop, clk, rst_n, advance && c_valid_reg && c_load_reg,
                     !d_valid_reg, "load item passed on as a result")
endmodule

FILE: tb/sv/testbench.sv
`timescale 1ns / 1ps
module testbench;
    typedef logic signed [31:0] q_t;

    typedef struct {
        logic       act;
        logic [4:0] idx;
        q_t         val;
        q_t         px;
        q_t         py;
        q_t         pz;
    } vertex_item_t;

    typedef struct {
        q_t   sx;
        q_t   sy;
        q_t   w;
        logic bad;
    } screen_point_t;

    localparam int FB = wts_pkg::FRAC_BITS_DEF;
    localparam q_t ONE = 32'sd65536;

    logic clk = 1'b0;
    logic rst_n = 1'b0;
    logic in_valid = 1'b0;
    logic in_stall;
    logic action = 1'b0;
    logic [4:0] element_index = '0;
    q_t element_value = '0;
    q_t point_x = '0;
    q_t point_y = '0;
    q_t point_z = '0;
    logic out_valid;
    logic out_stall = 1'b0;
    q_t screen_x;
    q_t screen_y;
    q_t clip_w;
    logic bad_result;
    logic cfg_valid = 1'b0;
    logic cfg_ready;
    logic cfg_index = 1'b0;
    logic [15:0] cfg_data = '0;

    world_to_screen_projection_top dut (.*);

    always #4 clk = ~clk;

    // Shadow copy of the block's state
    q_t view_m[16];
    q_t proj_m[16];
    logic [15:0] scr_w;
    logic [15:0] scr_h;

    vertex_item_t  pending_q[$];
    screen_point_t expected_q[$];
    int accepted_cnt = 0;
    int result_cnt = 0;
    int flagged_cnt = 0;
    int mismatch_cnt = 0;
    int cfg_writes = 0;
    int hold_left = 0;
    bit hold_done = 1'b0;

    function automatic q_t sat32(input longint v, inout logic bad);
        if (v > 64'sd2147483647) begin
            bad = 1'b1;
            return 32'sh7fffffff;
        end
        if (v < -64'sd2147483648) begin
            bad = 1'b1;
            return 32'sh80000000;
        end
        return q_t'(v);
    endfunction

    // Row i of m times column vector v, each product floored to the Q format
    function automatic void mat_times_vec(input q_t m[16], input q_t v[4],
                                          output q_t r[4], inout logic bad);
        longint acc;
        longint prod;
        for (int i = 0; i < 4; i++) begin
            acc = 0;
            for (int j = 0; j < 4; j++) begin
                prod = longint'(m[i*4+j]) * longint'(v[j]);
                acc += prod >>> FB;
            end
            r[i] = sat32(acc, bad);
        end
    endfunction

    function automatic q_t scale_to_screen(input q_t c, input q_t w,
                                           input logic [15:0] size, inout logic bad);
        longint ndc;
        longint lim;
        lim = longint'(1) <<< 47;
        ndc = (longint'(c) * (longint'(1) <<< FB)) / longint'(w);
        if (ndc > lim) ndc = lim;
        if (ndc < -lim) ndc = -lim;
        return sat32((ndc * longint'({1'b0, size})) / 2, bad);
    endfunction

    function automatic void project_vertex(input vertex_item_t it);
        q_t p[4];
        q_t v[4];
        q_t c[4];
        screen_point_t r;
        logic bad;
        bad = 1'b0;
        if (it.act == wts_pkg::ACT_LOAD) begin
            if (it.idx[4]) proj_m[it.idx[3:0]] = it.val;
            else view_m[it.idx[3:0]] = it.val;
            return;
        end
        p[0] = it.px;
        p[1] = it.py;
        p[2] = it.pz;
        p[3] = ONE;
        mat_times_vec(view_m, p, v, bad);
        mat_times_vec(proj_m, v, c, bad);
        if (c[3] == 0) begin
            bad = 1'b1;
            r.sx = c[0] > 0 ? 32'sh7fffffff : (c[0] < 0 ? 32'sh80000000 : 32'sd0);
            r.sy = c[1] > 0 ? 32'sh7fffffff : (c[1] < 0 ? 32'sh80000000 : 32'sd0);
        end else begin
            r.sx = scale_to_screen(c[0], c[3], scr_w, bad);
            r.sy = scale_to_screen(c[1], c[3], scr_h, bad);
        end
        r.w = c[3];
        r.bad = bad;
        expected_q.push_back(r);
    endfunction

    // Idle with a 12 percent chance, except in a quiet window mid-run
    function automatic bit take_gap();
        if (accepted_cnt >= 450 && accepted_cnt < 650) return 1'b0;
        return $urandom_range(99) < 12;
    endfunction

    // Driver: record the accepted item, then offer the next one
    always @(posedge clk) begin
        vertex_item_t it;
        if (rst_n) begin
            if (in_valid && !in_stall) begin
                it.act = action;
                it.idx = element_index;
                it.val = element_value;
                it.px = point_x;
                it.py = point_y;
                it.pz = point_z;
                project_vertex(it);
                accepted_cnt <= accepted_cnt + 1;
            end
            if (!in_valid || !in_stall) begin
                if (pending_q.size() == 0 || take_gap()) begin
                    in_valid <= 1'b0;
                end else begin
                    it = pending_q.pop_front();
                    in_valid <= 1'b1;
                    action <= it.act;
                    element_index <= it.idx;
                    element_value <= it.val;
                    point_x <= it.px;
                    point_y <= it.py;
                    point_z <= it.pz;
                end
            end
        end
    end

    // Receiver: random stalls plus one long hold-off to back up the pipeline
    always @(posedge clk) begin
        if (rst_n) begin
            if (!hold_done && accepted_cnt >= 300) begin
                hold_done <= 1'b1;
                hold_left <= 400;
                out_stall <= 1'b1;
            end else if (hold_left > 0) begin
                hold_left <= hold_left - 1;
                out_stall <= 1'b1;
            end else begin
                out_stall <= take_gap();
            end
        end
    end

    // Monitor: compare each accepted result against the oldest prediction
    always @(posedge clk) begin
        screen_point_t e;
        if (rst_n && out_valid && !out_stall) begin
            result_cnt <= result_cnt + 1;
            if (bad_result) flagged_cnt <= flagged_cnt + 1;
            if (expected_q.size() == 0) begin
                mismatch_cnt <= mismatch_cnt + 1;
                if (mismatch_cnt < 10)
                    $display("unexpected result sx=%0d sy=%0d w=%0d bad=%0b",
                             screen_x, screen_y, clip_w, bad_result);
            end else begin
                e = expected_q.pop_front();
                if (e.sx !== screen_x || e.sy !== screen_y || e.w !== clip_w ||
                    e.bad !== bad_result) begin
                    mismatch_cnt <= mismatch_cnt + 1;
                    if (mismatch_cnt < 10)
                        $display("result %0d: exp sx=%0d sy=%0d w=%0d bad=%0b, got sx=%0d sy=%0d w=%0d bad=%0b",
                                 result_cnt, e.sx, e.sy, e.w, e.bad,
                                 screen_x, screen_y, clip_w, bad_result);
                end
            end
        end
    end

    task automatic push_load(input int idx, input q_t val);
        vertex_item_t it;
        it.act = wts_pkg::ACT_LOAD;
        it.idx = idx[4:0];
        it.val = val;
        it.px = $urandom;
        it.py = $urandom;
        it.pz = $urandom;
        pending_q.push_back(it);
    endtask

    task automatic push_point(input q_t x, input q_t y, input q_t z);
        vertex_item_t it;
        it.act = wts_pkg::ACT_TRANSFORM;
        it.idx = 5'($urandom);
        it.val = $urandom;
        it.px = x;
        it.py = y;
        it.pz = z;
        pending_q.push_back(it);
    endtask

    // Wait until the pipeline is empty, trailing loads included
    task automatic drain();
        while (pending_q.size() != 0 || in_valid || expected_q.size() != 0)
            @(posedge clk);
        repeat (80) @(posedge clk);
    endtask

    task automatic write_cfg(input logic idx, input logic [15:0] data);
        @(posedge clk);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data <= data;
        do @(posedge clk); while (!(cfg_valid && cfg_ready));
        if (idx == wts_pkg::CFG_WIDTH) scr_w = data;
        else scr_h = data;
        cfg_writes++;
        cfg_valid <= 1'b0;
    endtask

    function automatic q_t small_q(input int range_int);
        return $signed($urandom_range(2 * range_int)) - range_int;
    endfunction

    // Well-formed frame: modest view, perspective-like projection, many points
    task automatic random_frame(input int n_points);
        for (int i = 0; i < 16; i++)
            push_load(i, (i % 5 == 0) ? ONE + small_q(1 << 16) : small_q(1 << 15));
        for (int i = 16; i < 32; i++)
            push_load(i, small_q(1 << 17));
        if ($urandom_range(3) != 0) begin
            // w = -z, the usual camera convention
            push_load(28, 0);
            push_load(29, 0);
            push_load(30, -ONE);
            push_load(31, 0);
        end
        for (int i = 0; i < n_points; i++) begin
            case ($urandom_range(9))
                0: push_point($urandom, $urandom, $urandom);
                1: push_load($urandom_range(31), $urandom);
                default: push_point(small_q(100 << 16), small_q(100 << 16),
                                    small_q(100 << 16));
            endcase
        end
    endtask

    initial begin
        scr_w = wts_pkg::WIDTH_RESET;
        scr_h = wts_pkg::HEIGHT_RESET;
        for (int i = 0; i < 16; i++) begin
            view_m[i] = '0;
            proj_m[i] = '0;
        end
        repeat (11) @(posedge clk);
        rst_n <= 1'b1;

        // Directed: cleared matrices give zero w, then identity and extremes
        push_point(32'sh7fffffff, 32'sh80000000, 32'sd0);
        for (int i = 0; i < 4; i++) begin
            push_load(i * 5, ONE);
            push_load(16 + i * 5, ONE);
        end
        push_point(ONE, -ONE, ONE);
        push_point(32'sh7fffffff, 32'sh7fffffff, 32'sh7fffffff);
        push_point(32'sh80000000, 32'sh80000000, 32'sh80000000);
        push_point(32'sd0, 32'sd0, -ONE);
        push_load(31, 0);
        push_point(ONE, -ONE, 32'sd5);
        push_load(30, ONE);
        push_point(32'sd3, 32'sd7, 32'sd1);
        push_load(0, 32'sh7fffffff);
        push_load(21, 32'sh80000000);
        push_point(32'sh7fffffff, 32'sh80000000, ONE);
        drain();

        write_cfg(wts_pkg::CFG_WIDTH, 16'd0);
        write_cfg(wts_pkg::CFG_HEIGHT, 16'hffff);
        random_frame(110);
        drain();
        write_cfg(wts_pkg::CFG_WIDTH, 16'hffff);
        write_cfg(wts_pkg::CFG_HEIGHT, 16'd0);
        random_frame(110);
        drain();
        for (int ph = 0; ph < 3; ph++) begin
            write_cfg(wts_pkg::CFG_WIDTH, 16'($urandom));
            write_cfg(wts_pkg::CFG_HEIGHT, 16'($urandom));
            random_frame(110);
            drain();
        end
        write_cfg(wts_pkg::CFG_WIDTH, wts_pkg::WIDTH_RESET);
        write_cfg(wts_pkg::CFG_HEIGHT, wts_pkg::HEIGHT_RESET);
        random_frame(150);
        drain();

        $display("projected %0d results (%0d flagged) from %0d items over %0d screen-size writes",
                 result_cnt, flagged_cnt, accepted_cnt, cfg_writes);
        if (mismatch_cnt == 0 && expected_q.size() == 0) begin
            $display("SCOREBOARD CLEAN");
        end else begin
            $display("%0d mismatches, %0d results still outstanding",
                     mismatch_cnt, expected_q.size());
            $display("SCOREBOARD MISMATCH");
        end
        $finish;
    end

    initial begin
        #4000000;
        $display("timeout with %0d results outstanding", expected_q.size());
        $display("SCOREBOARD MISMATCH");
        $finish;
    end
endmodule
